[rtl/luhn_pkg.sv]
// ----------------------------------------------------------------------------
// Luhn check package
// Shared widths, constants, brand codes and digit helpers.
// ----------------------------------------------------------------------------
package luhn_pkg;

   localparam int NUM_BCD        = 20;
   localparam int BCD_W          = 4 * NUM_BCD;
   localparam int BIN_W          = 64;
   localparam int MAX_DIGITS_DEF = 19;
   localparam int NUM_GROUPS     = 4;
   localparam int GROUP_LEN      = NUM_BCD / NUM_GROUPS;

   typedef enum logic [1:0] {
      BRAND_NONE  = 2'd0,
      BRAND_FOUR  = 2'd1,
      BRAND_FIVE  = 2'd2,
      BRAND_THREE = 2'd3
   } brand_type;

   // add three to a digit of five or more
   function automatic logic [3:0] dabble_adj(input logic [3:0] d);
      dabble_adj = (d >= 4'd5) ? 4'(d + 4'd3) : d;
   endfunction

   // digit contribution; odd places are doubled, two-digit products add digit sum
   function automatic logic [3:0] contrib(input logic [3:0] d, input logic odd);
      logic [4:0] x;
      x = odd ? {d, 1'b0} : {1'b0, d};
      if (x >= 5'd10) begin
         x = 5'(x - 5'd9);
      end
      contrib = x[3:0];
   endfunction

endpackage

[rtl/luhn_card_number_check.sv]
// ----------------------------------------------------------------------------
// Luhn card number check
// Binary to decimal conversion, Luhn mod 10 test, length and brand class.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one card number per request, binary, in req_tdata.
//   rsp_ channel: one result per request, in the same order.
//   The number is converted to decimal by a 64-stage shift-and-add-three
//   pipeline, one input bit per stage, followed by three stages that count
//   digits and form partial sums, total the sums and pick the leading pair,
//   then reduce mod 10 and classify the brand.
//   Throughput: one request per cycle unless a stall holds the pipeline.
//   A value with more than MAX_DIGITS digits gives an all-zero result.
//   Reset clears every valid bit; the pipeline is then empty.
//   When rsp_tready is low with a result waiting, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module luhn_card_number_check #(
   parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // card_number[63:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // luhn_ok, brand[1:0], digit_count[4:0],
                                    // leading_pair[6:0], zero pad
);

   localparam int NB  = luhn_pkg::NUM_BCD;
   localparam int BW  = luhn_pkg::BCD_W;
   localparam int IW  = luhn_pkg::BIN_W;
   localparam int NG  = luhn_pkg::NUM_GROUPS;
   localparam int GL  = luhn_pkg::GROUP_LEN;

   logic adv;

   logic [BW-1:0] bcd_ff [0:IW-1];
   logic [IW-1:0] bin_ff [0:IW-2];
   logic          dv_ff  [0:IW-1];

   logic [BW-1:0] a_dig_ff, a_dig_in;
   logic [4:0]    a_cnt_ff, a_cnt_in;
   logic [5:0]    a_grp_ff [0:NG-1];
   logic [5:0]    a_grp_in [0:NG-1];
   logic          a_v_ff;

   logic [7:0]    b_tot_ff, b_tot_in;
   logic [6:0]    b_lead_ff, b_lead_in;
   logic [4:0]    b_cnt_ff;
   logic          b_v_ff;

   logic          o_ok_ff, o_ok_in;
   luhn_pkg::brand_type o_brand_ff, o_brand_in;
   logic [4:0]    o_cnt_ff, o_cnt_in;
   logic [6:0]    o_lead_ff, o_lead_in;
   logic          o_v_ff;

   assign adv        = !o_v_ff || rsp_tready;
   assign req_tready = adv;

   for (genvar s = 0; s < IW; s++) begin : g_dab
      logic [BW-1:0] src_bcd, adj;
      logic [IW-1:0] src_bin;
      logic          src_v;
      if (s == 0) begin : g_first
         assign src_bcd = '0;
         assign src_bin = req_tdata;
         assign src_v   = req_tvalid;
      end else begin : g_next
         assign src_bcd = bcd_ff[s-1];
         assign src_bin = bin_ff[s-1];
         assign src_v   = dv_ff[s-1];
      end
      always_comb begin
         for (int j = 0; j < NB; j++) begin
            adj[4*j +: 4] = luhn_pkg::dabble_adj(src_bcd[4*j +: 4]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s] <= 1'b0;
         end else if (adv) begin
            dv_ff[s] <= src_v;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            bcd_ff[s] <= {adj[BW-2:0], src_bin[IW-1]};
         end
      end
      if (s < IW - 1) begin : g_bin
         always_ff @(posedge clock) begin
            if (adv) begin
               bin_ff[s] <= {src_bin[IW-2:0], 1'b0};
            end
         end
      end
   end

   // count digits, partial Luhn sums
   always_comb begin
      a_dig_in = bcd_ff[IW-1];
      a_cnt_in = '0;
      for (int j = 0; j < NB; j++) begin
         if (a_dig_in[4*j +: 4] != 4'd0) begin
            a_cnt_in = 5'(j + 1);
         end
      end
      for (int g = 0; g < NG; g++) begin
         a_grp_in[g] = '0;
         for (int k = 0; k < GL; k++) begin
            a_grp_in[g] = 6'(a_grp_in[g] + 6'(luhn_pkg::contrib(
               a_dig_in[4*(g*GL+k) +: 4], 1'((g*GL+k) % 2))));
         end
      end
   end

   // total and leading pair
   always_comb begin
      logic [3:0] hi, lo;
      hi = '0;
      lo = '0;
      b_tot_in = '0;
      for (int g = 0; g < NG; g++) begin
         b_tot_in = 8'(b_tot_in + 8'(a_grp_ff[g]));
      end
      for (int j = 0; j < NB; j++) begin
         if (a_cnt_ff == 5'(j + 1)) begin
            hi = a_dig_ff[4*j +: 4];
         end
         if (a_cnt_ff == 5'(j + 2)) begin
            lo = a_dig_ff[4*j +: 4];
         end
      end
      if (a_cnt_ff == 5'd1) begin
         b_lead_in = {3'b000, hi};
      end else begin
         b_lead_in = 7'({hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo});
      end
   end

   // mod 10 and brand
   always_comb begin
      logic [15:0] prod;
      logic [4:0]  q;
      logic [7:0]  rem;
      logic        over;
      prod = 16'(b_tot_ff) * 16'd205;
      q    = prod[15:11];
      rem  = 8'(b_tot_ff - 8'(q) * 8'd10);
      over = 32'(b_cnt_ff) > MAX_DIGITS;
      o_ok_in    = (rem == 8'd0) && !over;
      o_brand_in = luhn_pkg::BRAND_NONE;
      if (o_ok_in) begin
         priority if ((b_cnt_ff == 5'd13 || b_cnt_ff == 5'd16)
                      && b_lead_ff >= 7'd40 && b_lead_ff <= 7'd49) begin
            o_brand_in = luhn_pkg::BRAND_FOUR;
         end else if (b_cnt_ff == 5'd16 && b_lead_ff >= 7'd51 && b_lead_ff <= 7'd55) begin
            o_brand_in = luhn_pkg::BRAND_FIVE;
         end else if (b_cnt_ff == 5'd15 && (b_lead_ff == 7'd34 || b_lead_ff == 7'd37)) begin
            o_brand_in = luhn_pkg::BRAND_THREE;
         end else begin
            o_brand_in = luhn_pkg::BRAND_NONE;
         end
      end
      o_cnt_in  = over ? 5'd0 : b_cnt_ff;
      o_lead_in = over ? 7'd0 : b_lead_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= dv_ff[IW-1];
         b_v_ff <= a_v_ff;
         o_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_dig_ff   <= a_dig_in;
         a_cnt_ff   <= a_cnt_in;
         a_grp_ff   <= a_grp_in;
         b_tot_ff   <= b_tot_in;
         b_lead_ff  <= b_lead_in;
         b_cnt_ff   <= a_cnt_ff;
         o_ok_ff    <= o_ok_in;
         o_brand_ff <= o_brand_in;
         o_cnt_ff   <= o_cnt_in;
         o_lead_ff  <= o_lead_in;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = {1'b0, o_lead_ff, o_cnt_ff, o_brand_ff, o_ok_ff};

   a_brand_needs_ok: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && o_brand_ff != luhn_pkg::BRAND_NONE |-> o_ok_ff)
      else $error("brand set on failed check");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      o_v_ff |-> 32'(o_cnt_ff) <= MAX_DIGITS)
      else $error("digit count out of range");
   a_lead_range: assert property (@(posedge clock) disable iff (reset)
      o_v_ff |-> o_lead_ff <= 7'd99)
      else $error("leading pair out of range");
   a_zero_lead: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && o_cnt_ff == 5'd0 |-> o_lead_ff == 7'd0)
      else $error("leading pair without digits");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      o_v_ff && !rsp_tready |=> o_v_ff && $stable(o_lead_ff) && $stable(o_cnt_ff))
      else $error("result lost under stall");

endmodule
